@@ hdl/stereo_point_reprojection_core_macros.svh @@
// Assertion macros for the stereo point reprojection core
`ifndef STEREO_POINT_REPROJECTION_CORE_MACROS_SVH
`define STEREO_POINT_REPROJECTION_CORE_MACROS_SVH

// Check a property on every rising clock edge, even during reset
`define SRPC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

// Check a property outside reset
`define SRPC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

@@ hdl/srpc_pkg.sv @@
// ----------------------------------------------------------------------------
// srpc_pkg
// Shared constants, types and helpers of the stereo point reprojection core.
// ----------------------------------------------------------------------------
package srpc_pkg;

   localparam int COORD_W         = 16;
   localparam int COORD_FRAC_BITS = 4;
   localparam int OUT_FRAC_BITS   = 16;
   localparam int NUM_REGS        = 8;
   localparam int CSR_W           = 64;
   localparam int CSR_IDX_W       = 4;
   localparam int REG_SEL_W       = $clog2(NUM_REGS);
   localparam int ENTRY_W         = 32;
   localparam int VEC_W           = COORD_W + 1;
   localparam int PROD_W          = ENTRY_W + VEC_W;
   localparam int H_W             = PROD_W + 2;
   localparam int MAG_W           = H_W - 1;
   localparam int SCALE           = 1000;
   localparam int D_W             = MAG_W + 10;
   localparam int CMP_W           = D_W + OUT_FRAC_BITS;
   localparam int Q_W             = 32;
   localparam int NUM_CELLS       = Q_W;
   localparam int LANES           = 3;
   localparam int ONE_FIX         = 1 << COORD_FRAC_BITS;

   typedef logic [NUM_REGS-1:0][CSR_W-1:0] qmat_type;

   typedef struct packed {
      logic [D_W-1:0] rem;
      logic [Q_W-1:0] pend;
      logic [Q_W-1:0] quo;
      logic           neg;
      logic           ovf;
   } lane_type;

   typedef struct packed {
      lane_type [LANES-1:0] lane;
      logic [D_W-1:0]       dvs;
      logic                 invalid;
   } cell_data_type;

   function automatic logic signed [ENTRY_W-1:0] q_entry(qmat_type q, int row, int col);
      logic [CSR_W-1:0] word;
      word = q[row * 2 + col / 2];
      q_entry = (col % 2 == 1) ? $signed(word[CSR_W-1:ENTRY_W]) : $signed(word[ENTRY_W-1:0]);
   endfunction

endpackage

@@ hdl/srpc_if.sv @@
// ----------------------------------------------------------------------------
// srpc_req_if / srpc_rsp_if
// Valid/ready channels for feature transactions and point transactions.
// ----------------------------------------------------------------------------
interface srpc_req_if;
   logic                               valid;
   logic                               ready;
   logic [srpc_pkg::COORD_W-1:0]       left_x;
   logic [srpc_pkg::COORD_W-1:0]       left_y;
   logic [srpc_pkg::COORD_W-1:0]       right_x;

   modport source (output valid, output left_x, output left_y, output right_x, input ready);
   modport sink   (input valid, input left_x, input left_y, input right_x, output ready);
endinterface

interface srpc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [srpc_pkg::Q_W-1:0]    point_x;
   logic signed [srpc_pkg::Q_W-1:0]    point_y;
   logic signed [srpc_pkg::Q_W-1:0]    point_z;
   logic                               point_invalid;

   modport source (output valid, output point_x, output point_y, output point_z,
                   output point_invalid, input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   input point_invalid, output ready);
endinterface

@@ hdl/srpc_front.sv @@
// ----------------------------------------------------------------------------
// srpc_front
// Matrix product, row sums, scale and divider setup, four pipeline stages.
// ----------------------------------------------------------------------------
module srpc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [srpc_pkg::COORD_W-1:0]        left_x,
   input  logic [srpc_pkg::COORD_W-1:0]        left_y,
   input  logic [srpc_pkg::COORD_W-1:0]        right_x,
   input  srpc_pkg::qmat_type                  q_regs,
   output logic                                out_valid,
   input  logic                                out_ready,
   output srpc_pkg::cell_data_type             out_data
);

   logic [3:0] vld_ff;
   logic [3:0] adv;

   logic signed [srpc_pkg::VEC_W-1:0]  vec [4];
   logic signed [srpc_pkg::PROD_W-1:0] prod_in [4][4];
   logic signed [srpc_pkg::PROD_W-1:0] prod_ff [4][4];
   logic signed [srpc_pkg::H_W-1:0]    h_in [4];
   logic signed [srpc_pkg::H_W-1:0]    h_ff [4];
   logic [srpc_pkg::MAG_W-1:0]         mag_in [3];
   logic [srpc_pkg::MAG_W-1:0]         mag_ff [3];
   logic [srpc_pkg::MAG_W-1:0]         mag3;
   logic [2:0]                         neg_in, neg_ff;
   logic [srpc_pkg::D_W-1:0]           dvs_in, dvs_ff;
   logic                               inv_in, inv_ff;
   srpc_pkg::cell_data_type            data_in, data_ff;

   assign adv[3] = !vld_ff[3] || out_ready;
   assign adv[2] = !vld_ff[2] || adv[3];
   assign adv[1] = !vld_ff[1] || adv[2];
   assign adv[0] = !vld_ff[0] || adv[1];
   assign in_ready  = adv[0];
   assign out_valid = vld_ff[3];
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= in_valid;
         if (adv[1]) vld_ff[1] <= vld_ff[0];
         if (adv[2]) vld_ff[2] <= vld_ff[1];
         if (adv[3]) vld_ff[3] <= vld_ff[2];
      end
   end

   always_comb begin
      vec[0] = $signed({1'b0, left_x});
      vec[1] = $signed({1'b0, left_y});
      vec[2] = $signed({1'b0, left_x}) - $signed({1'b0, right_x});
      vec[3] = srpc_pkg::VEC_W'(srpc_pkg::ONE_FIX);
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            prod_in[r][c] = srpc_pkg::q_entry(q_regs, r, c) * vec[c];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         h_in[r] = srpc_pkg::H_W'(prod_ff[r][0]) + srpc_pkg::H_W'(prod_ff[r][1])
                 + srpc_pkg::H_W'(prod_ff[r][2]) + srpc_pkg::H_W'(prod_ff[r][3]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = h_ff[i][srpc_pkg::H_W-1] ? srpc_pkg::MAG_W'(-h_ff[i])
                                              : srpc_pkg::MAG_W'(h_ff[i]);
         neg_in[i] = h_ff[i][srpc_pkg::H_W-1] ^ h_ff[3][srpc_pkg::H_W-1];
      end
      mag3 = h_ff[3][srpc_pkg::H_W-1] ? srpc_pkg::MAG_W'(-h_ff[3])
                                      : srpc_pkg::MAG_W'(h_ff[3]);
      dvs_in = srpc_pkg::D_W'(mag3) * srpc_pkg::D_W'(srpc_pkg::SCALE);
      inv_in = (h_ff[3] == '0);
   end

   always_comb begin
      data_in.dvs     = dvs_ff;
      data_in.invalid = inv_ff;
      for (int i = 0; i < 3; i++) begin
         data_in.lane[i].rem  = srpc_pkg::D_W'(mag_ff[i] >> srpc_pkg::OUT_FRAC_BITS);
         data_in.lane[i].pend = {mag_ff[i][srpc_pkg::OUT_FRAC_BITS-1:0],
                                 {(srpc_pkg::Q_W - srpc_pkg::OUT_FRAC_BITS){1'b0}}};
         data_in.lane[i].quo  = '0;
         data_in.lane[i].neg  = neg_ff[i];
         data_in.lane[i].ovf  = srpc_pkg::CMP_W'(mag_ff[i])
                                >= {dvs_ff, {srpc_pkg::OUT_FRAC_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) prod_ff <= prod_in;
      if (adv[1]) h_ff <= h_in;
      if (adv[2]) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
         dvs_ff <= dvs_in;
         inv_ff <= inv_in;
      end
      if (adv[3]) data_ff <= data_in;
   end

endmodule

@@ hdl/srpc_div_cell.sv @@
// ----------------------------------------------------------------------------
// srpc_div_cell
// One restoring division step for three lanes; produces one quotient bit per lane.
// ----------------------------------------------------------------------------
module srpc_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  srpc_pkg::cell_data_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output srpc_pkg::cell_data_type out_data
);

   logic                    vld_ff;
   srpc_pkg::cell_data_type data_in, data_ff;
   logic [srpc_pkg::D_W:0]  trial [srpc_pkg::LANES];
   logic                    ge [srpc_pkg::LANES];

   assign in_ready  = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in = in_data;
      for (int i = 0; i < srpc_pkg::LANES; i++) begin
         trial[i] = {in_data.lane[i].rem, in_data.lane[i].pend[srpc_pkg::Q_W-1]};
         ge[i]    = trial[i] >= {1'b0, in_data.dvs};
         data_in.lane[i].rem  = ge[i] ? srpc_pkg::D_W'(trial[i] - {1'b0, in_data.dvs})
                                      : srpc_pkg::D_W'(trial[i]);
         data_in.lane[i].pend = in_data.lane[i].pend << 1;
         data_in.lane[i].quo  = {in_data.lane[i].quo[srpc_pkg::Q_W-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) data_ff <= data_in;
   end

endmodule

@@ hdl/stereo_point_reprojection_core.sv @@
// ----------------------------------------------------------------------------
// stereo_point_reprojection_core
// Pipeline: 4 front stages, 32 division cells, 1 output register; the first front
// stage loads on the edge that accepts a transaction.
// Throughput: one transaction per cycle unless stalled; each cell retires one bit.
// Reset: synchronous, clears all valid flags and the matrix registers to zero.
// ----------------------------------------------------------------------------
module stereo_point_reprojection_core (
   input  logic                              clock,
   input  logic                              reset,
   srpc_req_if.sink                          req_chan,
   srpc_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [srpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [srpc_pkg::CSR_W-1:0]        csr_write_data
);

   srpc_pkg::qmat_type      q_ff;
   logic                    cv [srpc_pkg::NUM_CELLS+1];
   logic                    cr [srpc_pkg::NUM_CELLS+1];
   srpc_pkg::cell_data_type cd [srpc_pkg::NUM_CELLS+1];

   logic                              rsp_valid_ff;
   logic signed [srpc_pkg::Q_W-1:0]   pt_ff [srpc_pkg::LANES];
   logic signed [srpc_pkg::Q_W-1:0]   pt_in [srpc_pkg::LANES];
   logic                              inv_ff;
   logic                              last_ready;
   srpc_pkg::lane_type                ln;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else if (csr_write_enable
                   && csr_index < srpc_pkg::CSR_IDX_W'(srpc_pkg::NUM_REGS)) begin
         q_ff[csr_index[srpc_pkg::REG_SEL_W-1:0]] <= csr_write_data;
      end
   end

   srpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .left_x    (req_chan.left_x),
      .left_y    (req_chan.left_y),
      .right_x   (req_chan.right_x),
      .q_regs    (q_ff),
      .out_valid (cv[0]),
      .out_ready (cr[0]),
      .out_data  (cd[0])
   );

   for (genvar k = 0; k < srpc_pkg::NUM_CELLS; k++) begin : g_cell
      srpc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[k]),
         .in_ready  (cr[k]),
         .in_data   (cd[k]),
         .out_valid (cv[k+1]),
         .out_ready (cr[k+1]),
         .out_data  (cd[k+1])
      );
   end

   assign last_ready = !rsp_valid_ff || rsp_chan.ready;
   assign cr[srpc_pkg::NUM_CELLS] = last_ready;

   always_comb begin
      ln = '0;
      for (int i = 0; i < srpc_pkg::LANES; i++) begin
         ln = cd[srpc_pkg::NUM_CELLS].lane[i];
         if (cd[srpc_pkg::NUM_CELLS].invalid) begin
            pt_in[i] = '0;
         end else if (!ln.neg) begin
            pt_in[i] = (ln.ovf || ln.quo[srpc_pkg::Q_W-1]) ? 32'sh7FFF_FFFF : $signed(ln.quo);
         end else begin
            pt_in[i] = (ln.ovf || ln.quo > 32'h8000_0000) ? 32'sh8000_0000
                                                          : $signed(-ln.quo);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (last_ready) begin
         rsp_valid_ff <= cv[srpc_pkg::NUM_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (last_ready) begin
         pt_ff  <= pt_in;
         inv_ff <= cd[srpc_pkg::NUM_CELLS].invalid;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.point_x       = pt_ff[0];
   assign rsp_chan.point_y       = pt_ff[1];
   assign rsp_chan.point_z       = pt_ff[2];
   assign rsp_chan.point_invalid = inv_ff;

endmodule

@@ hdl/srpc_checker.sv @@
// ----------------------------------------------------------------------------
// srpc_checker
// Port-level checks of the stereo point reprojection core.
// ----------------------------------------------------------------------------
`include "stereo_point_reprojection_core_macros.svh"

module srpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] point_x,
   input logic [31:0] point_y,
   input logic [31:0] point_z,
   input logic        point_invalid
);

   `SRPC_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "result valid after reset")

   `SRPC_ASSERT(a_invalid_zero, rsp_valid && point_invalid |-> point_x == 32'd0 && point_y == 32'd0 && point_z == 32'd0, "invalid point with nonzero coordinates")

   `SRPC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(point_x) && $stable(point_y) && $stable(point_z) && $stable(point_invalid), "stalled result changed")

endmodule

bind stereo_point_reprojection_core srpc_checker u_srpc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .point_x       (rsp_chan.point_x),
   .point_y       (rsp_chan.point_y),
   .point_z       (rsp_chan.point_z),
   .point_invalid (rsp_chan.point_invalid)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stereo point reprojection core testbench
// Drives matched feature transactions through the core under several
// reprojection matrices and checks every point transaction against an
// internal fixed-point predictor, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               invalid;
   } point_type;

   typedef enum logic [3:0] {
      Q_R0_C01 = 4'd0, Q_R0_C23 = 4'd1, Q_R1_C01 = 4'd2, Q_R1_C23 = 4'd3,
      Q_R2_C01 = 4'd4, Q_R2_C23 = 4'd5, Q_R3_C01 = 4'd6, Q_R3_C23 = 4'd7,
      Q_BAD_IDX = 4'd9
   } csr_idx_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                           csr_write_enable = 1'b0;
   logic [srpc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [srpc_pkg::CSR_W-1:0]     csr_write_data = '0;

   srpc_req_if req_chan ();
   srpc_rsp_if rsp_chan ();

   stereo_point_reprojection_core uut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [srpc_pkg::CSR_W-1:0] q_shadow [srpc_pkg::NUM_REGS];
   point_type        expected_points [$];
   bit               failed = 1'b0;
   bit               req_idle_en = 1'b0;
   bit               rsp_idle_en = 1'b0;
   int               rsp_hold_cycles = 0;

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.left_x  = '0;
      req_chan.left_y  = '0;
      req_chan.right_x = '0;
      rsp_chan.ready   = 1'b0;
      foreach (q_shadow[i]) q_shadow[i] = '0;
   end

   function automatic logic signed [63:0] matrix_entry(int row, int col);
      logic [63:0] word;
      word = q_shadow[row * 2 + col / 2];
      return (col % 2) ? 64'($signed(word[63:32])) : 64'($signed(word[31:0]));
   endfunction

   function automatic logic [31:0] metres_quotient(logic signed [63:0] num,
                                                   logic signed [63:0] den);
      bit          neg;
      bit          big;
      logic [63:0] n;
      logic [63:0] d;
      logic [63:0] q;
      logic [63:0] r;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = ((den < 0) ? -den : den) * 64'd1000;
      q = n / d;
      r = n % d;
      big = q > 64'hFFFF_FFFF;
      for (int i = 0; i < srpc_pkg::OUT_FRAC_BITS; i++) begin
         if (big) break;
         q = q << 1;
         r = r << 1;
         if (r >= d) begin
            r = r - d;
            q[0] = 1'b1;
         end
         if (q > 64'hFFFF_FFFF) big = 1'b1;
      end
      if (!neg) return (big || q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      if (big || q > 64'h8000_0000) return 32'h8000_0000;
      return 32'(64'h1_0000_0000 - q);
   endfunction

   function automatic point_type reproject(logic [15:0] lx, logic [15:0] ly, logic [15:0] rx);
      logic signed [63:0] v [4];
      logic signed [63:0] h [4];
      point_type          p;
      v[0] = {48'd0, lx};
      v[1] = {48'd0, ly};
      v[2] = $signed({48'd0, lx}) - $signed({48'd0, rx});
      v[3] = 64'sd1 << srpc_pkg::COORD_FRAC_BITS;
      for (int row = 0; row < 4; row++) begin
         h[row] = 0;
         for (int col = 0; col < 4; col++) h[row] += matrix_entry(row, col) * v[col];
      end
      p = '0;
      if (h[3] == 0) begin
         p.invalid = 1'b1;
      end else begin
         p.x = metres_quotient(h[0], h[3]);
         p.y = metres_quotient(h[1], h[3]);
         p.z = metres_quotient(h[2], h[3]);
      end
      return p;
   endfunction

   function automatic void note_expected(point_type p);
      expected_points = {expected_points, p};
   endfunction

   task automatic write_csr(csr_idx_type idx, logic [63:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx < srpc_pkg::NUM_REGS) q_shadow[idx] = data;
   endtask

   task automatic send_feature(logic [15:0] lx, logic [15:0] ly, logic [15:0] rx);
      while (req_idle_en && $urandom_range(99) < 20) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.left_x  <= lx;
      req_chan.left_y  <= ly;
      req_chan.right_x <= rx;
      do @(posedge clock); while (!req_chan.ready);
      note_expected(reproject(lx, ly, rx));
   endtask

   task automatic release_req();
      req_chan.valid <= 1'b0;
   endtask

   task automatic drain_points();
      release_req();
      wait (expected_points.size() == 0);
      repeat (45) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles <= rsp_hold_cycles - 1;
         rsp_chan.ready  <= 1'b0;
      end else begin
         rsp_chan.ready <= !(rsp_idle_en && $urandom_range(99) < 20);
      end
   end

   always @(posedge clock) begin
      point_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_points.size() == 0) begin
            $error("unexpected point transaction");
            failed = 1'b1;
         end else begin
            e = expected_points.pop_front();
            if (rsp_chan.point_x !== e.x) begin
               $error("point_x expected %0d actual %0d", e.x, rsp_chan.point_x);
               failed = 1'b1;
            end
            if (rsp_chan.point_y !== e.y) begin
               $error("point_y expected %0d actual %0d", e.y, rsp_chan.point_y);
               failed = 1'b1;
            end
            if (rsp_chan.point_z !== e.z) begin
               $error("point_z expected %0d actual %0d", e.z, rsp_chan.point_z);
               failed = 1'b1;
            end
            if (rsp_chan.point_invalid !== e.invalid) begin
               $error("point_invalid expected %0d actual %0d", e.invalid,
                      rsp_chan.point_invalid);
               failed = 1'b1;
            end
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [31:0] rand_entry();
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return $signed(32'($urandom_range(4096))) - 32'sd2048;
         default: return $urandom;
      endcase
   endfunction

   task automatic load_typical_matrix();
      // Q with fx-like identity, principal point offset, baseline on row 3
      write_csr(Q_R0_C01, {32'h0, 32'h0010_0000});
      write_csr(Q_R0_C23, {32'hF000_0000 + 32'($urandom_range(65535)), 32'h0});
      write_csr(Q_R1_C01, {32'h0010_0000, 32'h0});
      write_csr(Q_R1_C23, {32'hF800_0000 + 32'($urandom_range(65535)), 32'h0});
      write_csr(Q_R2_C01, {32'h0, 32'h0});
      write_csr(Q_R2_C23, {32'h2000_0000 + 32'($urandom_range(1 << 20)), 32'h0});
      write_csr(Q_R3_C01, {32'h0, 32'h0});
      write_csr(Q_R3_C23, {32'h0, 32'h0000_1000 + 32'($urandom_range(4095))});
   endtask

   task automatic load_random_matrix();
      for (int i = 0; i < srpc_pkg::NUM_REGS; i++)
         write_csr(csr_idx_type'(i), {rand_entry(), rand_entry()});
   endtask

   task automatic test_zero_scale();
      send_feature(16'd0, 16'd0, 16'd0);
      send_feature(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_feature(16'h1234, 16'h5678, 16'h9ABC);
      drain_points();
   endtask

   task automatic test_directed_extremes();
      logic [15:0] pick [4] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000};
      load_typical_matrix();
      write_csr(Q_BAD_IDX, rand64());
      for (int i = 0; i < 4; i++) begin
         send_feature(pick[i], pick[3 - i], pick[(i + 1) % 4]);
         send_feature(pick[i], pick[i], 16'hFFFF - pick[i]);
      end
      drain_points();
      // saturation both ways, zero disparity with zero scale
      write_csr(Q_R0_C01, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
      write_csr(Q_R1_C01, {32'h8000_0000, 32'h8000_0000});
      write_csr(Q_R3_C01, 64'h0);
      write_csr(Q_R3_C23, {32'h0000_0001, 32'h0});
      send_feature(16'hFFFF, 16'hFFFF, 16'h0000);
      send_feature(16'h0000, 16'h0000, 16'hFFFF);
      send_feature(16'h8000, 16'h0001, 16'h8000);
      drain_points();
      write_csr(Q_R3_C23, {32'h0, 32'h0010_0000});
      send_feature(16'h0, 16'h0, 16'h0);
      drain_points();
      write_csr(Q_R3_C23, {32'h8000_0000, 32'hFFFF_FFFF});
      send_feature(16'h4000, 16'hFFFF, 16'h1000);
      send_feature(16'h1000, 16'h0000, 16'h4000);
      drain_points();
   endtask

   task automatic random_features(int count, bit typical);
      logic [15:0] lx;
      logic [15:0] rx;
      for (int i = 0; i < count; i++) begin
         lx = 16'($urandom);
         if (typical && $urandom_range(9) < 8)
            rx = (lx > 16'd4096) ? lx - 16'($urandom_range(4096)) : 16'($urandom_range(lx));
         else
            rx = 16'($urandom);
         send_feature(lx, 16'($urandom), rx);
      end
   endtask

   task automatic test_random_streams();
      for (int phase = 0; phase < 6; phase++) begin
         if (phase % 2) load_random_matrix(); else load_typical_matrix();
         req_idle_en = (phase != 1);
         rsp_idle_en = (phase != 1);
         random_features(200, phase % 2 == 0);
         drain_points();
      end
   endtask

   task automatic test_backpressure();
      load_typical_matrix();
      req_idle_en = 1'b0;
      rsp_hold_cycles = 200;
      random_features(120, 1'b1);
      drain_points();
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zero_scale();
      test_directed_extremes();
      test_backpressure();
      test_random_streams();
      if (!failed) $display("** stereo_point_reprojection_core: PASSED **");
      else $display("** stereo_point_reprojection_core: FAILED **");
      $finish;
   end

   initial begin
      #200000;
      $display("** stereo_point_reprojection_core: FAILED **");
      $finish;
   end
endmodule
